// File: hdl/segment_sphere_intersect_macros.svh
// assertion macros shared by the rtl
`ifndef SEGMENT_SPHERE_INTERSECT_MACROS_SVH
`define SEGMENT_SPHERE_INTERSECT_MACROS_SVH

// condition holds in the same cycle
`define SSI_ASSERT_SAME(name, clk_sig, rstn_sig, cond, expect_cond) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |-> (expect_cond)) else $error("ssi: same-cycle check failed");

// condition holds in the next cycle
`define SSI_ASSERT_NEXT(name, clk_sig, rstn_sig, cond, expect_cond) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (cond) |=> (expect_cond)) else $error("ssi: next-cycle check failed");

`endif

// File: hdl/ssi_pkg.sv
package ssi_pkg;

    localparam int COORD_BITS_DEF = 24;

    // pipeline stage positions
    localparam int NUM_STAGES = 7;
    localparam int ST_DIFF    = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ABS     = 3;
    localparam int ST_PART    = 4;
    localparam int ST_ACC     = 5;
    localparam int ST_OUT     = 6;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // sign flags carried alongside the wide product compare
    typedef struct packed {
        logic c_neg;
        logic proj_neg;
        logic seg_neg;
        logic tail_ge;
    } flags_t;

endpackage

// File: hdl/ssi_query_if.sv
interface ssi_query_if #(
    parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
    logic signed [COORD_BITS-1:0] centre_x;
    logic signed [COORD_BITS-1:0] centre_y;
    logic signed [COORD_BITS-1:0] centre_z;
    logic        [COORD_BITS-2:0] sphere_radius;

    modport source (
        output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               centre_x, centre_y, centre_z, sphere_radius,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
               centre_x, centre_y, centre_z, sphere_radius,
        output ready
    );
endinterface

// File: hdl/ssi_result_if.sv
interface ssi_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

// File: hdl/ssi_front.sv
module ssi_front #(
    parameter int  COORD_BITS = ssi_pkg::COORD_BITS_DEF,
    localparam int SUM_W      = 2 * COORD_BITS + 4
) (
    input  logic                         clk,
    input  ssi_pkg::stage_en_t           en,
    input  logic signed [COORD_BITS-1:0] start_pt  [3],
    input  logic signed [COORD_BITS-1:0] dir_vec   [3],
    input  logic signed [COORD_BITS-1:0] centre_pt [3],
    input  logic        [COORD_BITS-2:0] radius,
    output logic signed [SUM_W-1:0]      proj,
    output logic signed [SUM_W-1:0]      vv,
    output logic signed [SUM_W-1:0]      c
);
    import ssi_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int VD_W   = 2 * COORD_BITS + 1;
    localparam int VV_W   = 2 * COORD_BITS;
    localparam int DD_W   = 2 * COORD_BITS + 2;
    localparam int RR_W   = 2 * COORD_BITS - 2;

    logic signed [DIFF_W-1:0]     diff_reg [3];
    logic signed [COORD_BITS-1:0] dir_reg  [3];
    logic        [COORD_BITS-2:0] rad_reg;

    logic signed [VD_W-1:0] vd_prod [3];
    logic signed [VV_W-1:0] vv_prod [3];
    logic signed [DD_W-1:0] dd_prod [3];
    logic        [RR_W-1:0] rr_prod;

    logic signed [VD_W-1:0] vd_reg [3];
    logic signed [VV_W-1:0] vv_sq_reg [3];
    logic signed [DD_W-1:0] dd_reg [3];
    logic        [RR_W-1:0] rr_reg;

    logic signed [SUM_W-1:0] proj_reg;
    logic signed [SUM_W-1:0] vv_reg;
    logic signed [SUM_W-1:0] c_reg;

    // stage: offset from the sphere centre
    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= DIFF_W'(start_pt[i]) - DIFF_W'(centre_pt[i]);
                dir_reg[i]  <= dir_vec[i];
            end
            rad_reg <= radius;
        end
    end

    // stage: one multiplier per term
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vd_prod[i] = VD_W'(dir_reg[i]) * VD_W'(diff_reg[i]);
            vv_prod[i] = VV_W'(dir_reg[i]) * VV_W'(dir_reg[i]);
            dd_prod[i] = DD_W'(diff_reg[i]) * DD_W'(diff_reg[i]);
        end
        rr_prod = RR_W'(rad_reg) * RR_W'(rad_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            for (int i = 0; i < 3; i++)
            begin
                vd_reg[i]    <= vd_prod[i];
                vv_sq_reg[i] <= vv_prod[i];
                dd_reg[i]    <= dd_prod[i];
            end
            rr_reg <= rr_prod;
        end
    end

    // stage: dot products and squared lengths
    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            proj_reg <= SUM_W'(vd_reg[0]) + SUM_W'(vd_reg[1]) + SUM_W'(vd_reg[2]);
            vv_reg   <= SUM_W'(vv_sq_reg[0]) + SUM_W'(vv_sq_reg[1])
                      + SUM_W'(vv_sq_reg[2]);
            c_reg    <= SUM_W'(dd_reg[0]) + SUM_W'(dd_reg[1]) + SUM_W'(dd_reg[2])
                      - signed'(SUM_W'(rr_reg));
        end
    end

    assign proj = proj_reg;
    assign vv   = vv_reg;
    assign c    = c_reg;

endmodule

// File: hdl/ssi_disc.sv
module ssi_disc #(
    parameter int  COORD_BITS = ssi_pkg::COORD_BITS_DEF,
    localparam int SUM_W      = 2 * COORD_BITS + 4
) (
    input  logic                    clk,
    input  ssi_pkg::stage_en_t      en,
    input  logic signed [SUM_W-1:0] proj,
    input  logic signed [SUM_W-1:0] vv,
    input  logic signed [SUM_W-1:0] c,
    output logic                    disc_neg
);
    import ssi_pkg::*;

    // magnitudes fit in two halves of HALF_W bits each
    localparam int HALF_W = COORD_BITS + 1;
    localparam int MAG_W  = 2 * HALF_W;
    localparam int WIDE_W = 4 * HALF_W;

    logic signed [SUM_W-1:0] proj_neg;

    logic [MAG_W-1:0] a_reg;
    logic [MAG_W-1:0] vv_reg;
    logic [MAG_W-1:0] c_reg;

    logic [HALF_W-1:0] a_hi, a_lo, v_hi, v_lo, c_hi, c_lo;

    logic [MAG_W-1:0] aa_hh_reg, aa_hl_reg, aa_ll_reg;
    logic [MAG_W-1:0] vc_hh_reg, vc_hl_reg, vc_lh_reg, vc_ll_reg;

    logic [WIDE_W-1:0] aa_reg;
    logic [WIDE_W-1:0] vc_reg;

    // only consulted when proj is negative and c is not
    assign proj_neg = -proj;

    always_ff @(posedge clk)
    begin
        if (en[ST_ABS])
        begin
            a_reg  <= proj_neg[MAG_W-1:0];
            vv_reg <= vv[MAG_W-1:0];
            c_reg  <= c[MAG_W-1:0];
        end
    end

    assign a_hi = a_reg[MAG_W-1:HALF_W];
    assign a_lo = a_reg[HALF_W-1:0];
    assign v_hi = vv_reg[MAG_W-1:HALF_W];
    assign v_lo = vv_reg[HALF_W-1:0];
    assign c_hi = c_reg[MAG_W-1:HALF_W];
    assign c_lo = c_reg[HALF_W-1:0];

    // half-by-half partial products
    always_ff @(posedge clk)
    begin
        if (en[ST_PART])
        begin
            aa_hh_reg <= MAG_W'(a_hi) * MAG_W'(a_hi);
            aa_hl_reg <= MAG_W'(a_hi) * MAG_W'(a_lo);
            aa_ll_reg <= MAG_W'(a_lo) * MAG_W'(a_lo);
            vc_hh_reg <= MAG_W'(v_hi) * MAG_W'(c_hi);
            vc_hl_reg <= MAG_W'(v_hi) * MAG_W'(c_lo);
            vc_lh_reg <= MAG_W'(v_lo) * MAG_W'(c_hi);
            vc_ll_reg <= MAG_W'(v_lo) * MAG_W'(c_lo);
        end
    end

    // recombine proj^2 and vv*c
    always_ff @(posedge clk)
    begin
        if (en[ST_ACC])
        begin
            aa_reg <= (WIDE_W'(aa_hh_reg) << MAG_W)
                    + (WIDE_W'(aa_hl_reg) << (HALF_W + 1))
                    + WIDE_W'(aa_ll_reg);
            vc_reg <= (WIDE_W'(vc_hh_reg) << MAG_W)
                    + ((WIDE_W'(vc_hl_reg) + WIDE_W'(vc_lh_reg)) << HALF_W)
                    + WIDE_W'(vc_ll_reg);
        end
    end

    assign disc_neg = (aa_reg < vc_reg);

endmodule

// File: hdl/segment_sphere_intersect.sv
// segment / sphere intersection test
//
// query channel (sink): one request per segment, carrying the start point,
// the segment vector (t from 0 to 1), the sphere centre and radius, all in
// Q12.12 fixed point. result channel (source): one hit bit per request, in
// request order. a request is taken at a rising edge with valid and ready high.
//
// pipeline: seven register stages, the edge that accepts a request loads the
// first one and its hit is presented from the last. throughput: one request
// per cycle while the result is not stalled, every stage takes a new request
// each cycle that it advances; the wide disc product is split into
// (coord_bits+1)-square multipliers (25x25 by default) over two stages.
//
// each stage holds its request while the next one is occupied and stalled,
// so bubbles close up and requests keep entering while a finished result
// waits. ready only drops once every stage holds a request and the result
// is not taken. reset empties the pipeline: all stage valid bits clear, the
// data registers are left as they are. there is no other state.
`include "segment_sphere_intersect_macros.svh"

module segment_sphere_intersect #(
    parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ssi_query_if.sink    query,
    ssi_result_if.source result
);
    import ssi_pkg::*;

    localparam int SUM_W = 2 * COORD_BITS + 4;

    stage_en_t valid_reg;
    stage_en_t valid_next;
    stage_en_t en;

    logic signed [COORD_BITS-1:0] start_pt  [3];
    logic signed [COORD_BITS-1:0] dir_vec   [3];
    logic signed [COORD_BITS-1:0] centre_pt [3];

    logic signed [SUM_W-1:0] proj;
    logic signed [SUM_W-1:0] vv;
    logic signed [SUM_W-1:0] c;
    logic                    disc_neg;

    // seg_end = -(vv + proj); tail reduces to -vv * (c + vv + 2*proj)
    logic signed [SUM_W:0]   seg_sum;
    logic signed [SUM_W+1:0] tail_sum;

    flags_t flags_next;
    flags_t flags_abs_reg;
    flags_t flags_part_reg;
    flags_t flags_acc_reg;

    logic hit_next;
    logic hit_reg;

    // a request starting inside the sphere moves into the output stage
    logic start_in_due;

    // per-stage advance: a stage loads when empty or when it drains
    always_comb
    begin
        en[ST_OUT] = !valid_reg[ST_OUT] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[ST_DIFF] = en[ST_DIFF] ? query.valid : valid_reg[ST_DIFF];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign query.ready = en[ST_DIFF];

    assign start_pt[0]  = query.start_x;
    assign start_pt[1]  = query.start_y;
    assign start_pt[2]  = query.start_z;
    assign dir_vec[0]   = query.dir_x;
    assign dir_vec[1]   = query.dir_y;
    assign dir_vec[2]   = query.dir_z;
    assign centre_pt[0] = query.centre_x;
    assign centre_pt[1] = query.centre_y;
    assign centre_pt[2] = query.centre_z;

    // offsets, products and the three dot sums
    ssi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .en        (en),
        .start_pt  (start_pt),
        .dir_vec   (dir_vec),
        .centre_pt (centre_pt),
        .radius    (query.sphere_radius),
        .proj      (proj),
        .vv        (vv),
        .c         (c)
    );

    // sign of proj^2 - vv*c through split multipliers
    ssi_disc #(
        .COORD_BITS (COORD_BITS)
    ) u_disc (
        .clk      (clk),
        .en       (en),
        .proj     (proj),
        .vv       (vv),
        .c        (c),
        .disc_neg (disc_neg)
    );

    // cheap sign flags, carried beside the wide compare
    always_comb
    begin
        seg_sum  = (SUM_W+1)'(vv) + (SUM_W+1)'(proj);
        tail_sum = (SUM_W+2)'(c) + (SUM_W+2)'(vv) + ((SUM_W+2)'(proj) <<< 1);
        flags_next.c_neg    = c[SUM_W-1];
        flags_next.proj_neg = proj[SUM_W-1];
        flags_next.seg_neg  = (seg_sum > 0);
        flags_next.tail_ge  = (vv == '0) || (tail_sum <= 0);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ABS])
        begin
            flags_abs_reg <= flags_next;
        end
        if (en[ST_PART])
        begin
            flags_part_reg <= flags_abs_reg;
        end
        if (en[ST_ACC])
        begin
            flags_acc_reg <= flags_part_reg;
        end
        if (en[ST_OUT])
        begin
            hit_reg <= hit_next;
        end
    end

    // decision order: start inside, heading away, line misses, crossing
    always_comb
    begin
        if (flags_acc_reg.c_neg)
        begin
            hit_next = 1'b1;
        end
        else if (!flags_acc_reg.proj_neg)
        begin
            hit_next = 1'b0;
        end
        else if (disc_neg)
        begin
            hit_next = 1'b0;
        end
        else if (flags_acc_reg.seg_neg)
        begin
            hit_next = 1'b1;
        end
        else
        begin
            hit_next = flags_acc_reg.tail_ge;
        end
    end

    assign result.valid = valid_reg[ST_OUT];
    assign result.hit   = hit_reg;

    assign start_in_due = en[ST_OUT] && valid_reg[ST_ACC] && flags_acc_reg.c_neg;

    // an accepted request always lands in the first stage
    `SSI_ASSERT_NEXT(a_accept_enters, clk, rst_n, query.valid && query.ready, valid_reg[ST_DIFF])
    // an empty pipeline never refuses a request
    `SSI_ASSERT_SAME(a_empty_ready, clk, rst_n, valid_reg == '0, query.ready)
    // a full pipeline with a stalled result takes nothing more
    `SSI_ASSERT_SAME(a_full_stall, clk, rst_n, (&valid_reg) && !result.ready, !query.ready)
    // a start inside the sphere always reports a hit
    `SSI_ASSERT_NEXT(a_inside_hits, clk, rst_n, start_in_due, result.hit)

endmodule
